>>> rtl/core/etb_pkg.sv
// Package for the event timer bank: sizes, action and status codes,
// sequencer states and the transaction structs. No dependencies.

package etb_pkg;

	localparam int NUM_SLOTS   = 8;
	localparam int COUNT_WIDTH = 16;
	localparam int SLOT_W      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int EXT_W       = (NUM_SLOTS > 8) ? NUM_SLOTS : 8;

	localparam logic [2:0] ACT_TICK    = 3'd0;
	localparam logic [2:0] ACT_START_P = 3'd1;
	localparam logic [2:0] ACT_START_O = 3'd2;
	localparam logic [2:0] ACT_STOP    = 3'd3;
	localparam logic [2:0] ACT_RESTART = 3'd4;

	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_ALREADY    = 2'd1;
	localparam logic [1:0] ST_NOT_ACTIVE = 2'd2;
	localparam logic [1:0] ST_ZERO_TICKS = 2'd3;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CMD,
		S_SCAN,
		S_FIN
	} state_t;

	typedef struct packed {
		logic [2:0]  action;
		logic [2:0]  slot;
		logic [15:0] ticks;
		logic [7:0]  task_id;
		logic [7:0]  event_id;
		logic [7:0]  accept_mask;
	} req_item_t;

	typedef struct packed {
		logic        fire_valid;
		logic [2:0]  fired_slot;
		logic [7:0]  fired_task;
		logic [7:0]  fired_event;
		logic [1:0]  status;
		logic [7:0]  active_slots;
		logic        last;
	} rsp_item_t;

	typedef struct packed {
		logic [COUNT_WIDTH-1:0] dec;
		logic                   is_zero;
		logic                   is_one;
		logic                   is_two;
	} cnt_flags_t;

endpackage

>>> rtl/core/event_timer_bank.sv
// Event timer bank top level: slot storage, sequencer and output register.
// Depends on etb_pkg and etb_count_unit.

// A bank of NUM_SLOTS timer slots driven by one request transaction at a
// time. Start, stop and restart requests are accepted, then carried out
// in the execute state, and give exactly one response. A tick visits one
// slot per cycle, unless a fire waits on the output register, through a
// single shared decrement/compare unit, then passes a closing state; each
// successful fire gives one response in ascending slot order, and a tick
// without fires gives a single response with fire_valid low. Every
// response carries the armed map after the whole request, and last marks
// the final response of the request. The request side is busy while a
// request is in work; a response waiting in the output register stalls
// only the cycle that needs to load the next response.

module event_timer_bank import etb_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  req_item_t req,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output rsp_item_t rsp
);

	// Map the armed vector onto the eight reported bits.
	function automatic logic [7:0] active_view(input logic [NUM_SLOTS-1:0] a);
		logic [EXT_W-1:0] e;
		e = EXT_W'(a);
		return e[7:0];
	endfunction

	// Control state.
	state_t                 state_q, state_d;
	req_item_t              req_q;
	logic [SLOT_W-1:0]      idx_q;
	logic [NUM_SLOTS-1:0]   fire_mask_q;
	logic                   any_fire_q;
	logic [7:0]             act_q;
	logic [NUM_SLOTS-1:0]   armed_q;
	logic [NUM_SLOTS-1:0]   cnt_one_q;   // countdown equals one
	logic [NUM_SLOTS-1:0]   oneshot_q;   // reload interval is zero
	logic [NUM_SLOTS-1:0]   rl_one_q;    // reload interval equals one
	rsp_item_t              rsp_q;
	logic                   rsp_valid_q;

	// Slot payload.
	logic [COUNT_WIDTH-1:0] cnt_q    [NUM_SLOTS];
	logic [COUNT_WIDTH-1:0] reload_q [NUM_SLOTS];
	logic [7:0]             task_q   [NUM_SLOTS];
	logic [7:0]             event_q  [NUM_SLOTS];

	// Request decode at accept.
	logic                   req_acc;
	logic [EXT_W-1:0]       acc_ext;
	logic [NUM_SLOTS-1:0]   acc_slots;
	logic [NUM_SLOTS-1:0]   fire_in;

	assign req_acc   = req_valid && req_ready;
	assign acc_ext   = EXT_W'(req.accept_mask);
	assign acc_slots = acc_ext[NUM_SLOTS-1:0];
	// Armed slots sitting at one fire on this tick when their target accepts.
	assign fire_in   = armed_q & cnt_one_q & acc_slots;

	// Shared count unit: the request count in the execute cycle, else the
	// count of the slot under the scan pointer.
	logic [COUNT_WIDTH-1:0] ticks_c;
	logic [COUNT_WIDTH-1:0] cu_op;
	cnt_flags_t             cu_res;

	assign ticks_c = COUNT_WIDTH'(req_q.ticks);
	assign cu_op   = (state_q == S_CMD) ? ticks_c : cnt_q[idx_q];

	etb_count_unit u_count (
		.op  (cu_op),
		.res (cu_res)
	);

	// Slot addressed by a command.
	logic                   slot_inr;
	logic [SLOT_W-1:0]      sidx;
	logic                   slot_armed;

	assign slot_inr   = 32'(req_q.slot) < NUM_SLOTS;
	assign sidx       = SLOT_W'(req_q.slot);
	assign slot_armed = slot_inr && armed_q[sidx];

	// Scan step.
	logic [NUM_SLOTS-1:0]   cur_oh;
	logic                   fire_now;
	logic                   out_free;
	logic                   scan_last;

	assign cur_oh    = NUM_SLOTS'(1) << idx_q;
	assign fire_now  = fire_mask_q[idx_q];
	assign out_free  = !rsp_valid_q || rsp_ready;
	assign scan_last = (idx_q == SLOT_W'(NUM_SLOTS - 1));

	// Write controls, produced by the output block of the sequencer.
	logic                   wr_go;       // perform the slot update this cycle
	logic [SLOT_W-1:0]      widx;
	logic                   arm_set;
	logic                   arm_clr;
	logic                   cnt_wr;
	logic [COUNT_WIDTH-1:0] cnt_wval;
	logic                   cnt_one_wval;
	logic                   start_wr;
	logic [NUM_SLOTS-1:0]   armed_d;
	logic                   out_ld;
	rsp_item_t              out_d;
	logic [1:0]             cmd_st;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_acc) begin
					state_d = (req.action == ACT_TICK) ? S_SCAN : S_CMD;
				end
			end
			S_CMD: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			S_SCAN: begin
				if ((!fire_now || out_free) && scan_last) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (any_fire_q || out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Command decode: status and which update to apply.
	logic do_start, do_stop, do_restart;

	always_comb begin
		cmd_st     = ST_OK;
		do_start   = 1'b0;
		do_stop    = 1'b0;
		do_restart = 1'b0;
		unique case (req_q.action) inside
			ACT_START_P, ACT_START_O: begin
				if (!slot_inr) begin
					cmd_st = ST_NOT_ACTIVE;
				end else if (slot_armed) begin
					cmd_st = ST_ALREADY;
				end else if (cu_res.is_zero) begin
					cmd_st = ST_ZERO_TICKS;
				end else begin
					do_start = 1'b1;
				end
			end
			ACT_STOP: begin
				if (!slot_armed) begin
					cmd_st = ST_NOT_ACTIVE;
				end else begin
					do_stop = 1'b1;
				end
			end
			ACT_RESTART: begin
				if (cu_res.is_zero) begin
					cmd_st = ST_ZERO_TICKS;
				end else if (!slot_armed) begin
					cmd_st = ST_NOT_ACTIVE;
				end else begin
					do_restart = 1'b1;
				end
			end
			default: cmd_st = ST_OK;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		req_ready    = (state_q == S_IDLE);
		wr_go        = 1'b0;
		widx         = idx_q;
		arm_set      = 1'b0;
		arm_clr      = 1'b0;
		cnt_wr       = 1'b0;
		cnt_wval     = cu_res.dec;
		cnt_one_wval = cu_res.is_two;
		start_wr     = 1'b0;
		out_ld       = 1'b0;
		out_d        = '0;
		unique case (state_q)
			S_IDLE: begin
			end
			S_CMD: begin
				widx = sidx;
				if (out_free) begin
					wr_go        = 1'b1;
					arm_set      = do_start;
					arm_clr      = do_stop;
					start_wr     = do_start;
					cnt_wr       = do_start || do_restart;
					cnt_wval     = ticks_c;
					cnt_one_wval = cu_res.is_one;
					out_ld       = 1'b1;
					out_d.status = cmd_st;
					out_d.last   = 1'b1;
				end
			end
			S_SCAN: begin
				if (!fire_now || out_free) begin
					wr_go = 1'b1;
					if (armed_q[idx_q]) begin
						if (!cnt_one_q[idx_q]) begin
							// Count down; flag the slot once it sits at one.
							cnt_wr = 1'b1;
						end else if (fire_now) begin
							if (oneshot_q[idx_q]) begin
								arm_clr = 1'b1;
							end else begin
								cnt_wr       = 1'b1;
								cnt_wval     = reload_q[idx_q];
								cnt_one_wval = rl_one_q[idx_q];
							end
						end
						// Refused fire: hold the count at one for a retry.
					end
					if (fire_now) begin
						out_ld            = 1'b1;
						out_d.fire_valid  = 1'b1;
						out_d.fired_slot  = 3'(idx_q);
						out_d.fired_task  = task_q[idx_q];
						out_d.fired_event = event_q[idx_q];
						out_d.status      = ST_OK;
						out_d.last        = ((fire_mask_q & ~cur_oh) == '0);
					end
				end
			end
			S_FIN: begin
				if (!any_fire_q && out_free) begin
					out_ld     = 1'b1;
					out_d.last = 1'b1;
				end
			end
			default: begin
			end
		endcase
		out_d.active_slots = (state_q == S_CMD) ? active_view(armed_d) : act_q;
	end

	// Armed map after this cycle's update.
	always_comb begin
		armed_d = armed_q;
		if (wr_go && arm_set) begin
			armed_d[widx] = 1'b1;
		end
		if (wr_go && arm_clr) begin
			armed_d[widx] = 1'b0;
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= '0;
			fire_mask_q <= '0;
			any_fire_q  <= 1'b0;
			act_q       <= '0;
			armed_q     <= '0;
			cnt_one_q   <= '0;
			oneshot_q   <= '0;
			rl_one_q    <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			armed_q <= armed_d;
			if (req_acc) begin
				idx_q       <= '0;
				fire_mask_q <= (req.action == ACT_TICK) ? fire_in : '0;
				any_fire_q  <= (fire_in != '0);
				// Armed map at the end of the tick: fired one-shots drop out.
				act_q       <= active_view(armed_q & ~(fire_in & oneshot_q));
			end else if (state_q == S_SCAN && wr_go) begin
				idx_q       <= scan_last ? '0 : idx_q + SLOT_W'(1);
				fire_mask_q <= fire_mask_q & ~cur_oh;
			end
			if (wr_go && cnt_wr) begin
				cnt_one_q[widx] <= cnt_one_wval;
			end
			if (wr_go && start_wr) begin
				oneshot_q[widx] <= (req_q.action == ACT_START_O);
				rl_one_q[widx]  <= cu_res.is_one;
			end
			if (out_ld) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (req_acc) begin
			req_q <= req;
		end
		if (wr_go && cnt_wr) begin
			cnt_q[widx] <= cnt_wval;
		end
		if (wr_go && start_wr) begin
			reload_q[widx] <= (req_q.action == ACT_START_P) ? ticks_c : '0;
			task_q[widx]   <= req_q.task_id;
			event_q[widx]  <= req_q.event_id;
		end
		if (out_ld) begin
			rsp_q <= out_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// A fire response always reports a good status.
	a_fire_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (!rsp.fire_valid || rsp.status == ST_OK))
		else $error("fire response with error status");

	// Every fire due on a tick has been delivered when the scan closes.
	a_scan_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN) |-> (fire_mask_q == '0))
		else $error("pending fire left after scan");

	// An accepted request keeps the block busy in the cycle after the accept.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |=> !req_ready)
		else $error("request side ready right after accept");

endmodule

>>> rtl/core/etb_count_unit.sv
// Shared count unit of the event timer bank: decrement and small compares.
// Depends on etb_pkg.

module etb_count_unit import etb_pkg::*; (
	input  logic [COUNT_WIDTH-1:0] op,
	output cnt_flags_t             res
);

	always_comb begin
		res.dec     = op - COUNT_WIDTH'(1);
		res.is_zero = (op == '0);
		res.is_one  = (op == COUNT_WIDTH'(1));
		res.is_two  = (op == COUNT_WIDTH'(2));
	end

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for event_timer_bank: a directed table, then random
// start/stop/restart/tick traffic checked against a slot-by-slot predictor.
// Depends on etb_pkg and the event_timer_bank RTL.

module tb import etb_pkg::*; ();

	// Actions above restart are undefined; the bank must ignore them.
	localparam logic [2:0] ACT_UNUSED_FIRST = ACT_RESTART + 3'd1;
	localparam logic [2:0] ACT_UNUSED_LAST  = 3'd7;

	localparam int RANDOM_ITEMS = 300;
	localparam int HOLD_AT      = 60;   // random item that starts the long receiver hold
	localparam int PAUSE_AT     = 180;  // random item before which the sender drains
	localparam int LONG_HOLD    = 240;  // cycles the receiver keeps ready low
	localparam int TAIL_CYCLES  = 3 * (NUM_SLOTS + 2);
	localparam int QUIET_LIMIT  = 2000; // cycles with no transaction on either side
	localparam int REPORT_MAX   = 10;

	// One directed row: the request, and where it is obvious, the single
	// response pinned by hand instead of taken from the predictor.
	typedef struct packed {
		req_item_t req;
		logic      pinned;
		rsp_item_t pinned_rsp;
	} script_row_t;

	localparam script_row_t DIRECTED [27] = '{
		// nothing armed: a tick gives one empty response
		'{'{ACT_TICK,    3'd0, 16'h0000, 8'h00, 8'h00, 8'h00}, 1'b1,
		  '{1'b0, 3'd0, 8'h00, 8'h00, ST_OK, 8'h00, 1'b1}},
		// stop of an idle slot
		'{'{ACT_STOP,    3'd0, 16'h0000, 8'h00, 8'h00, 8'h00}, 1'b1,
		  '{1'b0, 3'd0, 8'h00, 8'h00, ST_NOT_ACTIVE, 8'h00, 1'b1}},
		// restart with zero ticks: zero check wins over the idle check
		'{'{ACT_RESTART, 3'd3, 16'h0000, 8'h00, 8'h00, 8'hFF}, 1'b1,
		  '{1'b0, 3'd0, 8'h00, 8'h00, ST_ZERO_TICKS, 8'h00, 1'b1}},
		// restart of an idle slot
		'{'{ACT_RESTART, 3'd3, 16'h0005, 8'h00, 8'h00, 8'h00}, 1'b1,
		  '{1'b0, 3'd0, 8'h00, 8'h00, ST_NOT_ACTIVE, 8'h00, 1'b1}},
		// start of an idle slot with zero ticks
		'{'{ACT_START_P, 3'd0, 16'h0000, 8'hFF, 8'h00, 8'h00}, 1'b1,
		  '{1'b0, 3'd0, 8'h00, 8'h00, ST_ZERO_TICKS, 8'h00, 1'b1}},
		'{'{ACT_START_P, 3'd0, 16'h0001, 8'hFF, 8'h00, 8'h00}, 1'b1,
		  '{1'b0, 3'd0, 8'h00, 8'h00, ST_OK, 8'h01, 1'b1}},
		// start of an armed slot: already-active wins over zero ticks
		'{'{ACT_START_O, 3'd0, 16'h0000, 8'h11, 8'h22, 8'h00}, 1'b1,
		  '{1'b0, 3'd0, 8'h00, 8'h00, ST_ALREADY, 8'h01, 1'b1}},
		'{'{ACT_START_O, 3'd7, 16'hFFFF, 8'h00, 8'hFF, 8'h00}, 1'b1,
		  '{1'b0, 3'd0, 8'h00, 8'h00, ST_OK, 8'h81, 1'b1}},
		'{'{ACT_START_O, 3'd3, 16'h0002, 8'hAA, 8'h55, 8'h00}, 1'b1,
		  '{1'b0, 3'd0, 8'h00, 8'h00, ST_OK, 8'h89, 1'b1}},
		// periodic slot 0 fires and reloads
		'{'{ACT_TICK,    3'd5, 16'h1234, 8'h5A, 8'hA5, 8'hFF}, 1'b0, '0},
		// every fire refused: counts park at one
		'{'{ACT_TICK,    3'd0, 16'h0000, 8'h00, 8'h00, 8'h00}, 1'b0, '0},
		// retry: slot 0 reloads, one-shot slot 3 clears
		'{'{ACT_TICK,    3'd0, 16'h0000, 8'h00, 8'h00, 8'h09}, 1'b0, '0},
		// restart of an armed slot loads only the count
		'{'{ACT_RESTART, 3'd7, 16'h0001, 8'h99, 8'h99, 8'h00}, 1'b0, '0},
		'{'{ACT_START_P, 3'd5, 16'h0001, 8'h12, 8'h34, 8'h00}, 1'b0, '0},
		'{'{ACT_TICK,    3'd0, 16'h0000, 8'h00, 8'h00, 8'hFF}, 1'b0, '0},
		'{'{ACT_STOP,    3'd0, 16'h0000, 8'h00, 8'h00, 8'h00}, 1'b0, '0},
		'{'{ACT_STOP,    3'd5, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF}, 1'b0, '0},
		// undefined action changes nothing
		'{'{ACT_UNUSED_LAST, 3'd6, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF}, 1'b0, '0},
		// arm every slot with a count of one, then fire them all at once
		'{'{ACT_START_P, 3'd0, 16'h0001, 8'h80, 8'h7F, 8'h00}, 1'b0, '0},
		'{'{ACT_START_O, 3'd1, 16'h0001, 8'h81, 8'h7E, 8'h00}, 1'b0, '0},
		'{'{ACT_START_P, 3'd2, 16'h0001, 8'h82, 8'h7D, 8'h00}, 1'b0, '0},
		'{'{ACT_START_O, 3'd3, 16'h0001, 8'h83, 8'h7C, 8'h00}, 1'b0, '0},
		'{'{ACT_START_P, 3'd4, 16'h0001, 8'h84, 8'h7B, 8'h00}, 1'b0, '0},
		'{'{ACT_START_O, 3'd5, 16'h0001, 8'h85, 8'h7A, 8'h00}, 1'b0, '0},
		'{'{ACT_START_P, 3'd6, 16'h0001, 8'h86, 8'h79, 8'h00}, 1'b0, '0},
		'{'{ACT_START_O, 3'd7, 16'h0001, 8'h87, 8'h78, 8'h00}, 1'b0, '0},
		'{'{ACT_TICK,    3'd0, 16'h0000, 8'h00, 8'h00, 8'hFF}, 1'b0, '0}
	};

	logic      clk = 1'b0;
	logic      arst_n;
	logic      req_valid;
	logic      req_ready;
	req_item_t req;
	logic      rsp_valid;
	logic      rsp_ready;
	rsp_item_t rsp;

	// Predicted slot state, kept in step with every accepted request.
	logic [COUNT_WIDTH-1:0] cnt_left   [NUM_SLOTS];
	logic [COUNT_WIDTH-1:0] reload_len [NUM_SLOTS];
	logic                   slot_armed [NUM_SLOTS];
	logic [7:0]             slot_task  [NUM_SLOTS];
	logic [7:0]             slot_evt   [NUM_SLOTS];

	rsp_item_t step_responses[$];  // responses of the request just accepted
	rsp_item_t owed_responses[$];  // responses the bank still has to deliver

	int n_sent;
	int n_ticks;
	int n_checked;
	int n_fires;
	int max_fires;
	int mismatches;
	int hold_asks;
	int holds_served;
	int unsigned quiet_cycles = 0;
	bit tx_steady;
	bit rx_steady;

	event_timer_bank u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always #2 clk = ~clk;

	function automatic void clear_slot(input int s);
		slot_armed[s] = 1'b0;
		cnt_left[s]   = '0;
		reload_len[s] = '0;
		slot_task[s]  = '0;
		slot_evt[s]   = '0;
	endfunction

	// Advance the slot state by one request and fill step_responses with
	// the responses it causes, in the order the bank must send them.
	function automatic void step_timer_slots(input req_item_t r);
		logic [COUNT_WIDTH-1:0] cnt;
		logic [1:0]             st;
		logic [7:0]             armed_map;
		rsp_item_t              one;
		int                     fires;

		cnt   = r.ticks[COUNT_WIDTH-1:0];
		st    = ST_OK;
		fires = 0;
		step_responses.delete();
		case (r.action)
			ACT_TICK: begin
				// Visit slots in ascending order; refused fires park at one.
				for (int s = 0; s < NUM_SLOTS; s++) begin
					if (slot_armed[s]) begin
						cnt_left[s] = cnt_left[s] - 1'b1;
						if (cnt_left[s] == '0) begin
							if (r.accept_mask[s]) begin
								one = '0;
								one.fire_valid  = 1'b1;
								one.fired_slot  = s[2:0];
								one.fired_task  = slot_task[s];
								one.fired_event = slot_evt[s];
								step_responses.push_back(one);
								fires++;
								if (reload_len[s] != '0)
									cnt_left[s] = reload_len[s];
								else
									clear_slot(s);
							end else begin
								cnt_left[s] = COUNT_WIDTH'(1);
							end
						end
					end
				end
				n_ticks++;
				n_fires += fires;
				if (fires > max_fires)
					max_fires = fires;
			end
			ACT_START_P, ACT_START_O: begin
				if (slot_armed[r.slot])
					st = ST_ALREADY;
				else if (cnt == '0)
					st = ST_ZERO_TICKS;
				else begin
					slot_armed[r.slot] = 1'b1;
					cnt_left[r.slot]   = cnt;
					reload_len[r.slot] = (r.action == ACT_START_P) ? cnt : '0;
					slot_task[r.slot]  = r.task_id;
					slot_evt[r.slot]   = r.event_id;
				end
			end
			ACT_STOP: begin
				if (!slot_armed[r.slot])
					st = ST_NOT_ACTIVE;
				else
					clear_slot(r.slot);
			end
			ACT_RESTART: begin
				if (cnt == '0)
					st = ST_ZERO_TICKS;
				else if (!slot_armed[r.slot])
					st = ST_NOT_ACTIVE;
				else
					cnt_left[r.slot] = cnt;
			end
			default: begin
			end
		endcase

		if (step_responses.size() == 0) begin
			one = '0;
			one.status = st;
			step_responses.push_back(one);
		end

		// Every response carries the armed map after the whole request.
		armed_map = '0;
		for (int s = 0; s < NUM_SLOTS && s < 8; s++)
			armed_map[s] = slot_armed[s];
		foreach (step_responses[k]) begin
			step_responses[k].active_slots = armed_map;
			step_responses[k].last = (k == step_responses.size() - 1);
		end
	endfunction

	// Mostly well-formed traffic with small counts so slots fire often,
	// with zero counts, long counts and undefined actions as noise.
	function automatic req_item_t random_request();
		req_item_t r;
		int        pick;

		r.slot     = 3'($urandom_range(0, NUM_SLOTS - 1));
		r.task_id  = 8'($urandom);
		r.event_id = 8'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 40)
			r.action = ACT_TICK;
		else if (pick < 55)
			r.action = ACT_START_P;
		else if (pick < 70)
			r.action = ACT_START_O;
		else if (pick < 80)
			r.action = ACT_STOP;
		else if (pick < 94)
			r.action = ACT_RESTART;
		else
			r.action = 3'($urandom_range(ACT_UNUSED_FIRST, ACT_UNUSED_LAST));
		pick = $urandom_range(0, 99);
		if (pick < 6)
			r.ticks = '0;
		else if (pick < 80)
			r.ticks = 16'($urandom_range(1, 4));
		else if (pick < 92)
			r.ticks = 16'($urandom_range(5, 40));
		else
			r.ticks = 16'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 50)
			r.accept_mask = 8'hFF;
		else if (pick < 60)
			r.accept_mask = 8'h00;
		else
			r.accept_mask = 8'($urandom);
		return r;
	endfunction

	function automatic string rsp_text(input rsp_item_t r);
		return $sformatf("fire=%0b slot=%0d task=%02h event=%02h status=%0d active=%02h last=%0b",
			r.fire_valid, r.fired_slot, r.fired_task, r.fired_event,
			r.status, r.active_slots, r.last);
	endfunction

	// Offer one request after a random gap, hold it until accepted, then
	// book the responses it owes. Call at a rising edge.
	task automatic push_request(input req_item_t item, input logic pinned,
			input rsp_item_t pinned_rsp);
		int gap;

		if ($urandom_range(0, 31) == 0)
			tx_steady = !tx_steady;
		gap = tx_steady ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req       <= item;
		req_valid <= 1'b1;
		do
			@(posedge clk);
		while (!req_ready);

		step_timer_slots(item);
		if (pinned)
			owed_responses.push_back(pinned_rsp);
		else
			foreach (step_responses[k])
				owed_responses.push_back(step_responses[k]);
		n_sent++;
	endtask

	// Drop valid and wait until the bank has delivered everything owed.
	task automatic drain_bank();
		req_valid <= 1'b0;
		@(posedge clk);
		while (owed_responses.size() != 0)
			@(posedge clk);
	endtask

	task automatic check_response(input rsp_item_t got);
		rsp_item_t due;
		string     bad;

		bad = "";
		due = '0;
		n_checked++;
		if (owed_responses.size() == 0) begin
			bad = " (no response owed)";
		end else begin
			due = owed_responses.pop_front();
			if (got.fire_valid !== due.fire_valid)
				bad = {bad, " fire_valid"};
			if (got.fired_slot !== due.fired_slot)
				bad = {bad, " fired_slot"};
			if (got.fired_task !== due.fired_task)
				bad = {bad, " fired_task"};
			if (got.fired_event !== due.fired_event)
				bad = {bad, " fired_event"};
			if (got.status !== due.status)
				bad = {bad, " status"};
			if (got.active_slots !== due.active_slots)
				bad = {bad, " active_slots"};
			if (got.last !== due.last)
				bad = {bad, " last"};
		end
		if (bad != "") begin
			mismatches++;
			if (mismatches <= REPORT_MAX)
				$display("mismatch%s: expected %s, got %s",
					bad, rsp_text(due), rsp_text(got));
		end
	endtask

	// Sample the response channel before the edge updates it.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready)
			check_response(rsp);
	end

	// Count cycles in which no transaction moves on either channel.
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		while (quiet_cycles < QUIET_LIMIT)
			@(posedge clk);
		$display("timeout: no transaction for %0d cycles, %0d responses still owed",
			QUIET_LIMIT, owed_responses.size());
		$display("end of test: mismatches");
		$finish;
	end

	// Receiver: stall a random number of cycles before each response, with
	// stretches of no stalls, and serve a long hold when the sender asks.
	initial begin
		int stall;

		rsp_ready    = 1'b0;
		holds_served = 0;
		rx_steady    = 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if ($urandom_range(0, 31) == 0)
				rx_steady = !rx_steady;
			if (hold_asks > holds_served) begin
				stall = LONG_HOLD;
				holds_served++;
			end else begin
				stall = rx_steady ? 0 : $urandom_range(0, 15);
			end
			if (stall > 0) begin
				rsp_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			do
				@(posedge clk);
			while (!rsp_valid);
		end
	end

	// Sender: reset, directed table, then random traffic, then drain.
	initial begin
		arst_n     = 1'b0;
		req_valid  = 1'b0;
		req        = '0;
		n_sent     = 0;
		n_ticks    = 0;
		n_checked  = 0;
		n_fires    = 0;
		max_fires  = 0;
		mismatches = 0;
		hold_asks  = 0;
		tx_steady  = 1'b0;
		for (int s = 0; s < NUM_SLOTS; s++)
			clear_slot(s);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[i])
			push_request(DIRECTED[i].req, DIRECTED[i].pinned, DIRECTED[i].pinned_rsp);

		// Let the bank empty out before the random part starts.
		drain_bank();

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			// Hold the receiver off while requests keep coming, so the
			// output register fills and the request side stalls.
			if (i == HOLD_AT)
				hold_asks++;
			if (i == PAUSE_AT)
				drain_bank();
			push_request(random_request(), 1'b0, '0);
		end

		drain_bank();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d requests (%0d ticks) and %0d checked responses",
			n_sent, n_ticks, n_checked);
		$display("slots fired %0d times, up to %0d on a single tick", n_fires, max_fires);
		if (mismatches == 0 && owed_responses.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

>>> filelist.f
rtl/core/etb_pkg.sv
rtl/core/etb_count_unit.sv
rtl/core/event_timer_bank.sv
tb/sv/tb.sv
